[rtl/qvr_pkg.sv]
// Shared types and constants for the quaternion rotation pipeline.
`timescale 1ns / 1ps

package qvr_pkg;

    localparam int COMP_W   = 16;
    localparam int COMP_MAX = 32767;
    localparam int COMP_MIN = -32768;

    typedef logic signed [COMP_W-1:0] comp_t;
    // index 0 = w, 1 = x, 2 = y, 3 = z
    typedef comp_t [3:0] quat_t;

    typedef enum logic {
        REQ_PRODUCT = 1'b0,
        REQ_ROTATE  = 1'b1
    } req_t;

endpackage

[rtl/qvr_qmul.sv]
// Two-stage pipelined Hamilton product with rounding and saturation.
`timescale 1ns / 1ps

module qvr_qmul import qvr_pkg::*; #(
    parameter int FRAC_BITS = 13
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  logic       conj_r,
    input  quat_t      l,
    input  quat_t      r,
    output logic       out_valid,
    output quat_t      o,
    output logic [3:0] clip
);

    localparam int PROD_W = 2 * COMP_W;
    localparam int ACC_W  = PROD_W + 3;

    localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(COMP_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(COMP_MIN);

    localparam logic [1:0] LI [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3}
    };
    localparam logic [1:0] RI [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd3, 2'd2},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };
    // bit j set: term j of the row is subtracted
    localparam logic [3:0] NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

    logic signed [PROD_W-1:0] prod_reg  [4][4];
    logic signed [PROD_W-1:0] prod_next [4][4];
    logic                     conj_reg;
    logic                     vld1_reg;
    quat_t                    o_reg, o_next;
    logic [3:0]               clip_reg, clip_next;
    logic                     vld2_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                prod_next[i][j] = $signed(l[LI[i][j]]) * $signed(r[RI[i][j]]);
            end
        end
    end

    always_comb begin
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] term;
        logic signed [ACC_W-1:0] shr;
        logic                    neg;
        o_next    = '0;
        clip_next = '0;
        for (int i = 0; i < 4; i++) begin
            acc = '0;
            for (int j = 0; j < 4; j++) begin
                neg  = NEG[i][j] ^ (conj_reg && (RI[i][j] != 2'd0));
                term = ACC_W'(prod_reg[i][j]);
                acc  = neg ? (acc - term) : (acc + term);
            end
            shr = (acc + RND) >>> FRAC_BITS;
            if (shr > SAT_HI) begin
                o_next[i]    = comp_t'(COMP_MAX);
                clip_next[i] = 1'b1;
            end else if (shr < SAT_LO) begin
                o_next[i]    = comp_t'(COMP_MIN);
                clip_next[i] = 1'b1;
            end else begin
                o_next[i]    = shr[COMP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            conj_reg <= conj_r;
            o_reg    <= o_next;
            clip_reg <= clip_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
        end
    end

    assign out_valid = vld2_reg;
    assign o         = o_reg;
    assign clip      = clip_reg;

endmodule

[rtl/quaternion_vector_rotation.sv]
// Top level: quaternion product / vector rotation, five-stage pipeline.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | req_type, left_w..z, right_w..z
//  m_      | out | m_valid / m_ready  | res_w..z, saturated
//
// From accept to m_valid: two stages for L*R (multiply, sum/round), two for
// T*conj(L), one output register. One word per cycle while the output is not stalled.
// A stalled output freezes the whole pipeline; s_ready = !m_valid | m_ready.
// Reset clears only the valid bits.
`timescale 1ns / 1ps

module quaternion_vector_rotation import qvr_pkg::*; #(
    parameter int FRAC_BITS = 13
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [15:0] s_left_w,
    input  logic [15:0] s_left_x,
    input  logic [15:0] s_left_y,
    input  logic [15:0] s_left_z,
    input  logic [15:0] s_right_w,
    input  logic [15:0] s_right_x,
    input  logic [15:0] s_right_y,
    input  logic [15:0] s_right_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_res_w,
    output logic [15:0] m_res_x,
    output logic [15:0] m_res_y,
    output logic [15:0] m_res_z,
    output logic        m_saturated
);

    logic       en;
    quat_t      l_in, r_in;
    logic       v1, v2;
    quat_t      t_q, p_q;
    logic [3:0] clip1, clip2;

    logic       mode_d1_reg, mode_d2_reg, mode_d3_reg, mode_d4_reg;
    quat_t      l_d1_reg, l_d2_reg;
    quat_t      t_d3_reg, t_d4_reg;
    logic [3:0] clip1_d3_reg, clip1_d4_reg;

    quat_t      res_reg, res_next;
    logic       sat_reg, sat_next;
    logic       out_valid_reg;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    assign l_in = {s_left_z, s_left_y, s_left_x, s_left_w};
    assign r_in = {s_right_z, s_right_y, s_right_x,
                   (s_req_type == REQ_ROTATE) ? comp_t'(0) : comp_t'(s_right_w)};

    qvr_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .conj_r    (1'b0),
        .l         (l_in),
        .r         (r_in),
        .out_valid (v1),
        .o         (t_q),
        .clip      (clip1)
    );

    qvr_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v1),
        .conj_r    (1'b1),
        .l         (t_q),
        .r         (l_d2_reg),
        .out_valid (v2),
        .o         (p_q),
        .clip      (clip2)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            mode_d1_reg  <= s_req_type;
            mode_d2_reg  <= mode_d1_reg;
            mode_d3_reg  <= mode_d2_reg;
            mode_d4_reg  <= mode_d3_reg;
            l_d1_reg     <= l_in;
            l_d2_reg     <= l_d1_reg;
            t_d3_reg     <= t_q;
            t_d4_reg     <= t_d3_reg;
            clip1_d3_reg <= clip1;
            clip1_d4_reg <= clip1_d3_reg;
            res_reg      <= res_next;
            sat_reg      <= sat_next;
        end
    end

    always_comb begin
        if (mode_d4_reg == REQ_ROTATE) begin
            res_next = {p_q[3], p_q[2], p_q[1], comp_t'(0)};
            sat_next = (|clip1_d4_reg) || (|clip2[3:1]);
        end else begin
            res_next = t_d4_reg;
            sat_next = |clip1_d4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v2;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_res_w     = res_reg[0];
    assign m_res_x     = res_reg[1];
    assign m_res_y     = res_reg[2];
    assign m_res_z     = res_reg[3];
    assign m_saturated = sat_reg;

endmodule

[rtl/qvr_checker.sv]
// Port-level checker for the quaternion rotation top level, with bind.
`timescale 1ns / 1ps

module qvr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_res_w,
    input logic [15:0] m_res_x,
    input logic [15:0] m_res_y,
    input logic [15:0] m_res_z,
    input logic        m_saturated
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res_w) && $stable(m_res_x)
            && $stable(m_res_y) && $stable(m_res_z) && $stable(m_saturated))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("valid output after reset");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while pipeline frozen");

endmodule

bind quaternion_vector_rotation qvr_checker u_qvr_checker (.*);

[verif/tb.sv]
// Self-checking testbench for the quaternion product / vector rotation pipeline.
`timescale 1ns / 1ps

module tb import qvr_pkg::*; ();

    localparam int FRAC_BITS = 13;
    localparam int N_RANDOM  = 1550;
    localparam int HOLD      = 250;
    localparam int LIMIT     = 300000;
    localparam int DRAIN     = 20;

    typedef struct packed {
        req_t  req;
        quat_t l;
        quat_t r;
    } qreq_t;

    typedef struct packed {
        quat_t res;
        logic  sat;
    } qres_t;

    typedef struct packed {
        qreq_t q;
        logic  chk;
        qres_t e;
    } stim_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_req_type  = 1'b0;
    logic [15:0] s_left_w    = '0;
    logic [15:0] s_left_x    = '0;
    logic [15:0] s_left_y    = '0;
    logic [15:0] s_left_z    = '0;
    logic [15:0] s_right_w   = '0;
    logic [15:0] s_right_x   = '0;
    logic [15:0] s_right_y   = '0;
    logic [15:0] s_right_z   = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [15:0] m_res_w;
    logic [15:0] m_res_x;
    logic [15:0] m_res_y;
    logic [15:0] m_res_z;
    logic        m_saturated;

    logic        fixed_on    = 1'b0;
    qres_t       fixed_res   = '0;
    logic        steady      = 1'b0;

    qres_t       pending_res[$];
    stim_t       cases[$];
    int          errors      = 0;
    int          cycle       = 0;

    quaternion_vector_rotation #(.FRAC_BITS(FRAC_BITS)) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_left_w   (s_left_w),
        .s_left_x   (s_left_x),
        .s_left_y   (s_left_y),
        .s_left_z   (s_left_z),
        .s_right_w  (s_right_w),
        .s_right_x  (s_right_x),
        .s_right_y  (s_right_y),
        .s_right_z  (s_right_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res_w    (m_res_w),
        .m_res_x    (m_res_x),
        .m_res_y    (m_res_y),
        .m_res_z    (m_res_z),
        .m_saturated(m_saturated)
    );

    always #5 aclk = ~aclk;

    function automatic quat_t qv(input comp_t w, input comp_t x, input comp_t y,
                                 input comp_t z);
        return {z, y, x, w};
    endfunction

    // {clip, value}: round half up, then clip to 16 bits
    function automatic logic [16:0] round_clip(input longint acc);
        longint s;
        s = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (s > COMP_MAX) return {1'b1, 16'h7fff};
        if (s < COMP_MIN) return {1'b1, 16'h8000};
        return {1'b0, s[15:0]};
    endfunction

    // l * r, or l * conj(r) when conj_r is set
    function automatic quat_t hamilton(input quat_t l, input quat_t r, input bit conj_r,
                                       output logic [3:0] clip);
        longint a, b, c, d, rw, rx, ry, rz;
        logic [16:0] o0, o1, o2, o3;
        a  = longint'($signed(l[0]));
        b  = longint'($signed(l[1]));
        c  = longint'($signed(l[2]));
        d  = longint'($signed(l[3]));
        rw = longint'($signed(r[0]));
        rx = longint'($signed(r[1]));
        ry = longint'($signed(r[2]));
        rz = longint'($signed(r[3]));
        if (conj_r) begin
            rx = -rx;
            ry = -ry;
            rz = -rz;
        end
        o0 = round_clip(a * rw - b * rx - c * ry - d * rz);
        o1 = round_clip(b * rw + a * rx + c * rz - d * ry);
        o2 = round_clip(a * ry - b * rz + c * rw + d * rx);
        o3 = round_clip(a * rz + b * ry - c * rx + d * rw);
        clip = {o3[16], o2[16], o1[16], o0[16]};
        return {o3[15:0], o2[15:0], o1[15:0], o0[15:0]};
    endfunction

    function automatic qres_t quat_eval(input qreq_t q);
        qres_t o;
        quat_t v, t;
        logic [3:0] c1, c2;
        if (q.req == REQ_PRODUCT) begin
            o.res = hamilton(q.l, q.r, 1'b0, c1);
            o.sat = |c1;
        end else begin
            v = q.r;
            v[0] = '0;
            t = hamilton(q.l, v, 1'b0, c1);
            o.res = hamilton(t, q.l, 1'b1, c2);
            o.res[0] = '0;
            o.sat = (|c1) | (|c2[3:1]);
        end
        return o;
    endfunction

    function automatic int idle_draw();
        return steady ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic comp_t rand_comp();
        return comp_t'($urandom_range(0, 65535));
    endfunction

    function automatic comp_t corner_comp();
        case ($urandom_range(0, 6))
            0: return comp_t'(COMP_MIN);
            1: return comp_t'(COMP_MAX);
            2: return comp_t'(-1);
            3: return comp_t'(0);
            4: return comp_t'(1);
            5: return comp_t'(8192);
            default: return comp_t'(-8192);
        endcase
    endfunction

    function automatic quat_t unit_quat();
        real c0, c1, c2, c3, n;
        c0 = real'(int'($urandom_range(0, 16384)) - 8192);
        c1 = real'(int'($urandom_range(0, 16384)) - 8192);
        c2 = real'(int'($urandom_range(0, 16384)) - 8192);
        c3 = real'(int'($urandom_range(0, 16384)) - 8192);
        n = $sqrt(c0 * c0 + c1 * c1 + c2 * c2 + c3 * c3);
        if (n < 1.0) return qv(8192, 0, 0, 0);
        return qv(comp_t'($rtoi(c0 * 8192.0 / n)), comp_t'($rtoi(c1 * 8192.0 / n)),
                  comp_t'($rtoi(c2 * 8192.0 / n)), comp_t'($rtoi(c3 * 8192.0 / n)));
    endfunction

    function automatic quat_t vec_quat();
        if ($urandom_range(0, 1))
            return qv(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        return qv(rand_comp(), comp_t'(int'($urandom_range(0, 32767)) - 16384),
                  comp_t'(int'($urandom_range(0, 32767)) - 16384),
                  comp_t'(int'($urandom_range(0, 32767)) - 16384));
    endfunction

    function automatic qreq_t random_req();
        qreq_t q;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                q.req = REQ_ROTATE;
                q.l = unit_quat();
                q.r = vec_quat();
            end
            4, 5: begin
                q.req = REQ_PRODUCT;
                q.l = unit_quat();
                q.r = unit_quat();
            end
            6, 7: begin
                q.req = REQ_PRODUCT;
                q.l = qv(rand_comp(), rand_comp(), rand_comp(), rand_comp());
                q.r = qv(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            end
            8: begin
                q.req = REQ_ROTATE;
                q.l = qv(rand_comp(), rand_comp(), rand_comp(), rand_comp());
                q.r = vec_quat();
            end
            default: begin
                q.req = req_t'($urandom_range(0, 1));
                q.l = qv(corner_comp(), corner_comp(), corner_comp(), corner_comp());
                q.r = qv(corner_comp(), corner_comp(), corner_comp(), corner_comp());
            end
        endcase
        return q;
    endfunction

    task automatic add_case(input req_t req, input quat_t l, input quat_t r,
                            input logic chk, input quat_t e, input logic esat);
        stim_t s;
        s.q.req = req;
        s.q.l = l;
        s.q.r = r;
        s.chk = chk;
        s.e.res = e;
        s.e.sat = esat;
        cases.push_back(s);
    endtask

    task automatic offer(input qreq_t q, input logic chk, input qres_t e);
        int gap;
        gap = idle_draw();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= q.req;
        s_left_w   <= q.l[0];
        s_left_x   <= q.l[1];
        s_left_y   <= q.l[2];
        s_left_z   <= q.l[3];
        s_right_w  <= q.r[0];
        s_right_x  <= q.r[1];
        s_right_y  <= q.r[2];
        s_right_z  <= q.r[3];
        fixed_on   <= chk;
        fixed_res  <= e;
        do @(posedge aclk); while (!s_ready);
    endtask

    // scoreboard: record accepted words, check returned words
    always @(posedge aclk) begin
        qreq_t cur;
        qres_t exp_res;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                cur.req = req_t'(s_req_type);
                cur.l = {s_left_z, s_left_y, s_left_x, s_left_w};
                cur.r = {s_right_z, s_right_y, s_right_x, s_right_w};
                pending_res.push_back(fixed_on ? fixed_res : quat_eval(cur));
            end
            if (m_valid && m_ready) begin
                if (pending_res.size() == 0) begin
                    $error("unexpected word: w=%h x=%h y=%h z=%h sat=%b",
                           m_res_w, m_res_x, m_res_y, m_res_z, m_saturated);
                    errors++;
                end else begin
                    exp_res = pending_res.pop_front();
                    if (m_res_w !== exp_res.res[0]) begin
                        $error("res_w: expected %h, actual %h", exp_res.res[0], m_res_w);
                        errors++;
                    end
                    if (m_res_x !== exp_res.res[1]) begin
                        $error("res_x: expected %h, actual %h", exp_res.res[1], m_res_x);
                        errors++;
                    end
                    if (m_res_y !== exp_res.res[2]) begin
                        $error("res_y: expected %h, actual %h", exp_res.res[2], m_res_y);
                        errors++;
                    end
                    if (m_res_z !== exp_res.res[3]) begin
                        $error("res_z: expected %h, actual %h", exp_res.res[3], m_res_z);
                        errors++;
                    end
                    if (m_saturated !== exp_res.sat) begin
                        $error("saturated: expected %b, actual %b", exp_res.sat, m_saturated);
                        errors++;
                    end
                end
            end
        end
    end

    // sink: random back-pressure plus one long hold to fill the pipeline
    initial begin : sink
        int gap;
        int taken;
        taken = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken == 400) begin
                m_ready <= 1'b0;
                repeat (HOLD) @(posedge aclk);
            end else begin
                gap = idle_draw();
                if (gap != 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    initial begin : watchdog
        while (cycle < LIMIT) begin
            @(posedge aclk);
            cycle++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : main
        qreq_t q;
        qres_t none;
        none = '0;

        add_case(REQ_PRODUCT, qv(8192, 0, 0, 0), qv(8192, 0, 0, 0), 1,
                 qv(8192, 0, 0, 0), 0);
        add_case(REQ_PRODUCT, qv(0, 0, 0, 0), qv(32767, -32768, 32767, -32768), 1,
                 qv(0, 0, 0, 0), 0);
        add_case(REQ_PRODUCT, qv(-32768, -32768, -32768, -32768),
                 qv(-32768, -32768, -32768, -32768), 1,
                 qv(-32768, 32767, 32767, 32767), 1);
        add_case(REQ_PRODUCT, qv(32767, 32767, 32767, 32767),
                 qv(32767, 32767, 32767, 32767), 1,
                 qv(-32768, 32767, 32767, 32767), 1);
        add_case(REQ_PRODUCT, qv(-32768, 0, 0, 0), qv(-32768, 0, 0, 0), 1,
                 qv(32767, 0, 0, 0), 1);
        // rounding ties go toward plus infinity
        add_case(REQ_PRODUCT, qv(1, 0, 0, 0), qv(4096, 0, 0, 0), 1, qv(1, 0, 0, 0), 0);
        add_case(REQ_PRODUCT, qv(1, 0, 0, 0), qv(-4096, 0, 0, 0), 1, qv(0, 0, 0, 0), 0);
        add_case(REQ_PRODUCT, qv(1, 0, 0, 0), qv(4095, 0, 0, 0), 1, qv(0, 0, 0, 0), 0);
        add_case(REQ_PRODUCT, qv(1, 0, 0, 0), qv(-4097, 0, 0, 0), 1, qv(-1, 0, 0, 0), 0);
        // basis products
        add_case(REQ_PRODUCT, qv(0, 8192, 0, 0), qv(0, 0, 8192, 0), 1,
                 qv(0, 0, 0, 8192), 0);
        add_case(REQ_PRODUCT, qv(0, 0, 8192, 0), qv(0, 8192, 0, 0), 1,
                 qv(0, 0, 0, -8192), 0);
        add_case(REQ_PRODUCT, qv(0, 8192, 0, 0), qv(0, 8192, 0, 0), 1,
                 qv(-8192, 0, 0, 0), 0);
        add_case(REQ_PRODUCT, qv(5793, 5793, 0, 0), qv(5793, 0, 5793, 0), 0, '0, 0);
        // rotation: right_w ignored, scalar forced to zero
        add_case(REQ_ROTATE, qv(8192, 0, 0, 0), qv(16'h1234, 1000, -2000, 3000), 1,
                 qv(0, 1000, -2000, 3000), 0);
        add_case(REQ_ROTATE, qv(8192, 0, 0, 0), qv(-32768, -32768, 32767, 0), 1,
                 qv(0, -32768, 32767, 0), 0);
        add_case(REQ_ROTATE, qv(0, 0, 0, 8192), qv(0, 8192, 0, 0), 1,
                 qv(0, -8192, 0, 0), 0);
        add_case(REQ_ROTATE, qv(0, 0, 0, 0), qv(32767, 32767, -32768, 32767), 1,
                 qv(0, 0, 0, 0), 0);
        add_case(REQ_ROTATE, qv(5793, 0, 0, 5793), qv(-1, 8192, 0, 0), 0, '0, 0);
        add_case(REQ_ROTATE, qv(5793, 5793, 0, 0), qv(7, 0, 8192, -8192), 0, '0, 0);
        // non-unit left quaternion scales the result
        add_case(REQ_ROTATE, qv(16384, 0, 0, 0), qv(0, 8192, -4096, 100), 0, '0, 0);
        add_case(REQ_ROTATE, qv(-32768, -32768, -32768, -32768),
                 qv(-32768, -32768, -32768, -32768), 0, '0, 0);
        add_case(REQ_ROTATE, qv(32767, 32767, 32767, 32767),
                 qv(32767, 32767, 32767, 32767), 0, '0, 0);
        add_case(REQ_ROTATE, qv(12000, -3000, 500, 9000), qv(0, 2000, 2000, -2000), 0,
                 '0, 0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (cases[i])
            offer(cases[i].q, cases[i].chk, cases[i].e);

        for (int i = 0; i < N_RANDOM; i++) begin
            steady = (i >= 600 && i < 800);
            q = random_req();
            offer(q, 1'b0, none);
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        while (pending_res.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        if (errors == 0 && pending_res.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
